/* src/gdeg_pkg.sv */
// ----------------------------------------------------------------------------
// gdeg_pkg
// shared types and constants of the gate dependency edge generator
// ----------------------------------------------------------------------------
`default_nettype none

package gdeg_pkg;

  localparam int MAX_WIRES = 1024;
  localparam int MAX_NODES = 65536;

  localparam int WIRE_W  = $clog2(MAX_WIRES);      // wire index
  localparam int WCNT_W  = WIRE_W + 1;             // wire_count register
  localparam int NODE_W  = 16;                     // node number on the bus
  localparam int CNT_W   = $clog2(MAX_NODES) + 1;  // node counter, holds MAX_NODES
  localparam int EPOCH_W = 8;                      // circuit tag kept in the table

  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONE  = EPOCH_W'(1);
  localparam logic [WIRE_W-1:0]  WIRE_LAST  = WIRE_W'(MAX_WIRES - 1);
  localparam logic [WCNT_W-1:0]  WIRE_LIMIT = WCNT_W'(MAX_WIRES);
  localparam logic [CNT_W-1:0]   NODE_LIMIT = CNT_W'(MAX_NODES);

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int KIND_W     = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE   = 3'd0,
    KIND_NOPRED = 3'd1,
    KIND_RANGE  = 3'd2,
    KIND_SAME   = 3'd3,
    KIND_OVER   = 3'd4
  } kind_t;

  // classified operation; kind is KIND_EDGE for a good operation
  typedef struct packed {
    kind_t               kind;
    logic [WIRE_W-1:0]   wire_a;
    logic [WIRE_W-1:0]   wire_b;
    logic [NODE_W-1:0]   node;
    logic [EPOCH_W-1:0]  epoch;
    logic                clear_first;
  } op_t;

  typedef struct packed {
    kind_t               kind;
    logic [NODE_W-1:0]   earlier_node;
    logic [NODE_W-1:0]   later_node;
    logic                last_result;
  } res_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]  tag;
    logic [NODE_W-1:0]   node;
  } entry_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } bk_state_t;

endpackage

`default_nettype wire

/* src/gate_dependency_edge_generator.sv */
// ----------------------------------------------------------------------------
// gate_dependency_edge_generator
// turns a stream of two-wire operations into dependency edges of their DAG
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                                tuser / tlast
// s_axis    in         [9:0] wire_a, [19:10] wire_b         tuser[0] start_circuit
// m_axis    out        [15:0] earlier_node, [31:16] later   tuser[2:0] kind,
//                                                           tlast last_result
// cfg       in         cfg_wr_data[10:0] wire_count         write on cfg_wr_en
//
// one operation per cycle enters while s_axis_tready is high; results leave at
// one per cycle while m_axis_tready is high. an operation whose two wires have
// different predecessors holds the resolve stage until both results are in the
// output buffer. the first result of an operation reaches m_axis through the
// front register, operation queue, resolve stage and output buffer. after
// reset the table is swept with s_axis_tready low; the same sweep runs once
// every 255 start_circuit flags, when the circuit tag wraps. each side stalls
// on its own: the operation queue and output buffer absorb a stalled neighbor.
//
`default_nettype none

module gate_dependency_edge_generator import gdeg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // operations in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,   // wire_a, wire_b, zero pad
  input  wire logic [0:0]             s_axis_tuser,   // start_circuit
  // results out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,   // earlier_node, later_node
  output logic [KIND_W-1:0]           m_axis_tuser,   // kind
  output logic                        m_axis_tlast,   // last_result
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [WCNT_W-1:0]      cfg_wr_data     // wire_count
);

  // front to queue
  logic q_push;
  op_t  q_in;
  logic q_full;
  // queue to back
  op_t  q_head;
  logic q_empty;
  logic q_pop;
  // back status: table sweep in progress
  logic clearing;

  // front: numbers operations, tracks the circuit tag, flags errors
  gdeg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_in)
  );

  // decouples classification from table lookup
  gdeg_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // back: last-writer table with forwarding, edge emission
  gdeg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* src/gdeg_front.sv */
// ----------------------------------------------------------------------------
// gdeg_front
// accepts operations, numbers them and flags the error cases
// ----------------------------------------------------------------------------
`default_nettype none

module gdeg_front import gdeg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]            s_axis_tuser,
  input  wire logic                  cfg_wr_en,
  input  wire logic [WCNT_W-1:0]     cfg_wr_data,
  input  wire logic                  clearing,
  input  wire logic                  q_full,
  output logic                       q_push,
  output op_t                        q_op
);

  logic [WCNT_W-1:0]  wire_count;
  logic [CNT_W-1:0]   node_cnt;
  logic [EPOCH_W-1:0] epoch;
  logic               op_valid;
  op_t                op;

  logic [WIRE_W-1:0]  wire_a;
  logic [WIRE_W-1:0]  wire_b;
  logic               start;
  logic [WCNT_W-1:0]  limit;
  logic [CNT_W-1:0]   cnt_eff;
  logic [EPOCH_W-1:0] epoch_eff;
  logic               wrap;
  kind_t              kind;
  logic               accept;

  assign wire_a = s_axis_tdata[WIRE_W-1:0];
  assign wire_b = s_axis_tdata[2*WIRE_W-1:WIRE_W];
  assign start  = s_axis_tuser[0];

  always_comb begin
    limit     = (wire_count < WIRE_LIMIT) ? wire_count : WIRE_LIMIT;
    cnt_eff   = start ? '0 : node_cnt;
    wrap      = start && (epoch == EPOCH_MAX);
    epoch_eff = !start ? epoch : (wrap ? EPOCH_ONE : epoch + EPOCH_ONE);
    if (({1'b0, wire_a} >= limit) || ({1'b0, wire_b} >= limit)) begin
      kind = KIND_RANGE;
    end else if (wire_a == wire_b) begin
      kind = KIND_SAME;
    end else if (cnt_eff >= NODE_LIMIT) begin
      kind = KIND_OVER;
    end else begin
      kind = KIND_EDGE;
    end
  end

  assign s_axis_tready = !clearing && (!op_valid || !q_full);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push        = op_valid && !q_full;
  assign q_op          = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      wire_count <= WIRE_LIMIT;
    end else if (cfg_wr_en) begin
      wire_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_cnt <= '0;
      epoch    <= EPOCH_ONE;
      op_valid <= 1'b0;
    end else if (accept) begin
      node_cnt <= (kind == KIND_EDGE) ? cnt_eff + CNT_W'(1) : cnt_eff;
      epoch    <= epoch_eff;
      op_valid <= 1'b1;
    end else if (q_push) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.kind        <= kind;
      op.wire_a      <= wire_a;
      op.wire_b      <= wire_b;
      op.node        <= cnt_eff[NODE_W-1:0];
      op.epoch       <= epoch_eff;
      op.clear_first <= wrap;
    end
  end

endmodule

`default_nettype wire

/* src/gdeg_opq.sv */
// ----------------------------------------------------------------------------
// gdeg_opq
// short queue of classified operations between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gdeg_opq import gdeg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire op_t   push_op,
  output logic       full,
  input  wire logic  pop,
  output op_t        head,
  output logic       empty
);

  op_t               slots [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr;
  logic [OPQ_AW-1:0] rd_ptr;
  logic [OPQ_AW:0]   count;

  assign full  = (count == (OPQ_AW + 1)'(OPQ_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OPQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OPQ_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (OPQ_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (OPQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

/* src/gdeg_back.sv */
// ----------------------------------------------------------------------------
// gdeg_back
// looks up predecessors in the last-writer table and emits the edges
// ----------------------------------------------------------------------------
`default_nettype none

module gdeg_back import gdeg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire op_t                    q_head,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [KIND_W-1:0]           m_axis_tuser,
  output logic                        m_axis_tlast
);

  // two banks: bank0 is written at wire_a, bank1 at wire_b
  entry_t bank0 [MAX_WIRES];
  entry_t bank1 [MAX_WIRES];

  bk_state_t         state;
  bk_state_t         state_next;
  logic [WIRE_W-1:0] sweep_idx;
  logic              swept;

  logic              x_valid;
  op_t               x_op;
  logic              x_phase;
  entry_t            rd0a, rd1a, rd0b, rd1b;
  logic              prev_valid;
  logic [WIRE_W-1:0] prev_a;
  logic [WIRE_W-1:0] prev_b;
  logic [NODE_W-1:0] prev_node;
  logic [EPOCH_W-1:0] prev_epoch;

  res_t              obuf [2];
  logic              owr_ptr;
  logic              ord_ptr;
  logic [1:0]        ocnt;

  logic              start_sweep;
  logic              x_emit;
  logic              x_done;
  logic              x_wr;
  logic              o_pop;
  logic [NODE_W:0]   look_a;
  logic [NODE_W:0]   look_b;
  logic              has_a;
  logic              has_b;
  res_t              res;
  entry_t            wr_ent;

  // newest valid node for a wire: forwarded write first, then the newer bank hit
  function automatic logic [NODE_W:0] find_pred(
    input entry_t            e0,
    input entry_t            e1,
    input logic [WIRE_W-1:0] w,
    input op_t               op,
    input logic              pv,
    input logic [WIRE_W-1:0] pa,
    input logic [WIRE_W-1:0] pb,
    input logic [NODE_W-1:0] pn,
    input logic [EPOCH_W-1:0] pe
  );
    logic h0;
    logic h1;
    logic fwd;
    logic [NODE_W-1:0] n;
    h0  = (e0.tag == op.epoch);
    h1  = (e1.tag == op.epoch);
    fwd = pv && (pe == op.epoch) && ((pa == w) || (pb == w));
    if (fwd) begin
      n = pn;
    end else if (h0 && h1) begin
      n = (e0.node > e1.node) ? e0.node : e1.node;
    end else if (h0) begin
      n = e0.node;
    end else begin
      n = e1.node;
    end
    return {fwd || h0 || h1, n};
  endfunction

  // ---- sweep control
  assign clearing    = (state == BK_CLEAR);
  assign start_sweep = !q_empty && q_head.clear_first && !swept && !x_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (sweep_idx == WIRE_LAST) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (start_sweep) begin
          state_next = BK_CLEAR;
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
      swept     <= 1'b0;
    end else begin
      if (state == BK_CLEAR) begin
        sweep_idx <= (sweep_idx == WIRE_LAST) ? '0 : sweep_idx + WIRE_W'(1);
      end
      if ((state == BK_CLEAR) && (sweep_idx == WIRE_LAST)) begin
        swept <= 1'b1;
      end else if (q_pop) begin
        swept <= 1'b0;
      end
    end
  end

  // ---- resolve stage
  always_comb begin
    look_a = find_pred(rd0a, rd1a, x_op.wire_a, x_op, prev_valid, prev_a, prev_b,
                       prev_node, prev_epoch);
    look_b = find_pred(rd0b, rd1b, x_op.wire_b, x_op, prev_valid, prev_a, prev_b,
                       prev_node, prev_epoch);
    has_a  = look_a[NODE_W];
    // same predecessor on both wires gives one edge
    has_b  = look_b[NODE_W] &&
             !(has_a && (look_a[NODE_W-1:0] == look_b[NODE_W-1:0]));

    res.kind         = KIND_EDGE;
    res.earlier_node = '0;
    res.later_node   = x_op.node;
    res.last_result  = 1'b1;
    if (x_op.kind != KIND_EDGE) begin
      res.kind       = x_op.kind;
      res.later_node = '0;
    end else if (!has_a && !has_b) begin
      res.kind = KIND_NOPRED;
    end else if (has_a && !x_phase) begin
      res.earlier_node = look_a[NODE_W-1:0];
      res.last_result  = !has_b;
    end else begin
      res.earlier_node = look_b[NODE_W-1:0];
    end
  end

  assign x_emit = x_valid && (ocnt != 2'd2);
  assign x_done = x_emit && res.last_result;
  assign x_wr   = x_done && (x_op.kind == KIND_EDGE);
  assign q_pop  = (state == BK_RUN) && !q_empty && !(q_head.clear_first && !swept) &&
                  (!x_valid || x_done);
  assign wr_ent = '{tag: x_op.epoch, node: x_op.node};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid    <= 1'b0;
      x_phase    <= 1'b0;
      prev_valid <= 1'b0;
    end else if (q_pop) begin
      x_valid    <= 1'b1;
      x_phase    <= 1'b0;
      // the resolving op writes on the same edge as this read
      prev_valid <= x_wr;
    end else if (x_done) begin
      x_valid    <= 1'b0;
    end else if (x_emit) begin
      x_phase    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_op       <= q_head;
      prev_a     <= x_op.wire_a;
      prev_b     <= x_op.wire_b;
      prev_node  <= x_op.node;
      prev_epoch <= x_op.epoch;
    end
  end

  // ---- table banks
  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) begin
      bank0[sweep_idx] <= '0;
    end else if (x_wr) begin
      bank0[x_op.wire_a] <= wr_ent;
    end
    if (q_pop) begin
      rd0a <= bank0[q_head.wire_a];
      rd0b <= bank0[q_head.wire_b];
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) begin
      bank1[sweep_idx] <= '0;
    end else if (x_wr) begin
      bank1[x_op.wire_b] <= wr_ent;
    end
    if (q_pop) begin
      rd1a <= bank1[q_head.wire_a];
      rd1b <= bank1[q_head.wire_b];
    end
  end

  // ---- output buffer, two entries
  assign o_pop         = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (ocnt != 2'd0);
  assign m_axis_tdata  = {obuf[ord_ptr].later_node, obuf[ord_ptr].earlier_node};
  assign m_axis_tuser  = obuf[ord_ptr].kind;
  assign m_axis_tlast  = obuf[ord_ptr].last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocnt    <= 2'd0;
    end else begin
      if (x_emit) begin
        owr_ptr <= !owr_ptr;
      end
      if (o_pop) begin
        ord_ptr <= !ord_ptr;
      end
      if (x_emit && !o_pop) begin
        ocnt <= ocnt + 2'd1;
      end else if (o_pop && !x_emit) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_emit) begin
      obuf[owr_ptr] <= res;
    end
  end

endmodule

`default_nettype wire
